>>> rtl/assert_macros.svh
// Assertion macros used by the checker file mpa_checker.sv.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/mpa_pkg.sv
// Package for the mean/mean-square accumulator: widths, limits, state codes.
// No dependencies.
package mpa_pkg;

    localparam int MAX_FRAME_LOG2 = 20;
    localparam int MAG_W   = 16;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int COUNT_W = 21;
    localparam int SUM_W   = 36;
    localparam int SQ_W    = 52;
    localparam int MS_W    = 32;
    localparam int STEP_W  = $clog2(SQ_W);

    localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(1) << MAX_FRAME_LOG2;
    localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(SQ_W - 1);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_MUL     = 6'b000010,
        ST_ACC     = 6'b000100,
        ST_DIV_SUM = 6'b001000,
        ST_DIV_SQ  = 6'b010000,
        ST_FIN     = 6'b100000
    } t_state;

endpackage

>>> rtl/mean_power_accumulator_unit.sv
// Mean and mean-square magnitude accumulator. A sample transaction runs the block
// through square and accumulate back to idle; a new sample is taken only in idle.
// A frame_end sample then runs 2 x 52 steps on the shared shift-subtract divider and
// a final state loads the output register; the block returns to idle and takes the
// next sample only once that register is free, later while the result is not taken.
// Reset (i_rst_n low, synchronous) clears the sequencer, accumulators, out valid.
module mean_power_accumulator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mpa_pkg::MAG_W-1:0]    i_magnitude,
    input  logic                         i_frame_end,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mpa_pkg::MAG_W-1:0]    o_mean_magnitude,
    output logic [mpa_pkg::MS_W-1:0]     o_mean_square,
    output logic [mpa_pkg::COUNT_W-1:0]  o_sample_count,
    output logic                         o_overflowed
);

    // sequencer
    mpa_pkg::t_state r_state, n_state;

    // captured sample and its square
    logic [mpa_pkg::MAG_W-1:0]   r_mag;
    logic                        r_last;
    logic [mpa_pkg::PROD_W-1:0]  r_prod;

    // frame accumulators
    logic [mpa_pkg::COUNT_W-1:0] r_count, n_count;
    logic [mpa_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [mpa_pkg::SQ_W-1:0]    r_sq, n_sq;
    logic                        r_ovf, n_ovf;

    // shared divider: quotient shifts in where the dividend shifts out
    logic [mpa_pkg::SQ_W-1:0]    r_quo, n_quo;
    logic [mpa_pkg::COUNT_W-1:0] r_rem, n_rem;
    logic [mpa_pkg::STEP_W-1:0]  r_step;
    logic [mpa_pkg::COUNT_W:0]   w_trial;
    logic                        w_ge;

    // held quotients until the output register is free
    logic [mpa_pkg::MAG_W-1:0]   r_mean_hold;
    logic [mpa_pkg::MS_W-1:0]    r_ms_hold;

    // output register
    logic                        r_out_valid;
    logic [mpa_pkg::MAG_W-1:0]   r_mean;
    logic [mpa_pkg::MS_W-1:0]    r_ms;
    logic [mpa_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_ovf;

    logic w_in_take;
    logic w_out_free;

    assign o_in_ready  = (r_state == mpa_pkg::ST_IDLE);
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[mpa_pkg::SQ_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_count});
    assign n_rem   = w_ge ? mpa_pkg::COUNT_W'(w_trial - {1'b0, r_count})
                          : w_trial[mpa_pkg::COUNT_W-1:0];
    assign n_quo   = {r_quo[mpa_pkg::SQ_W-2:0], w_ge};

    // accumulate step; a sample beyond the frame limit only flags overflow
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_ovf   = r_ovf;
        if (r_count < mpa_pkg::FRAME_LIMIT) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + mpa_pkg::SUM_W'(r_mag);
            n_sq    = r_sq + mpa_pkg::SQ_W'(r_prod);
        end else begin
            n_ovf   = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpa_pkg::ST_IDLE:    if (i_in_valid) n_state = mpa_pkg::ST_MUL;
            mpa_pkg::ST_MUL:     n_state = mpa_pkg::ST_ACC;
            mpa_pkg::ST_ACC:     n_state = r_last ? mpa_pkg::ST_DIV_SUM : mpa_pkg::ST_IDLE;
            mpa_pkg::ST_DIV_SUM: if (r_step == mpa_pkg::LAST_STEP) n_state = mpa_pkg::ST_DIV_SQ;
            mpa_pkg::ST_DIV_SQ:  if (r_step == mpa_pkg::LAST_STEP) n_state = mpa_pkg::ST_FIN;
            mpa_pkg::ST_FIN:     if (w_out_free) n_state = mpa_pkg::ST_IDLE;
            default:             n_state = mpa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpa_pkg::ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // taken result frees the register unless a new one lands this cycle
            if (r_out_valid && i_out_ready && !(r_state == mpa_pkg::ST_FIN && w_out_free)) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == mpa_pkg::ST_ACC) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_sq    <= n_sq;
                r_ovf   <= n_ovf;
            end

            // publish the result and start a fresh frame
            if (r_state == mpa_pkg::ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sum       <= '0;
                r_sq        <= '0;
                r_ovf       <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_mag  <= i_magnitude;
            r_last <= i_frame_end;
        end

        if (r_state == mpa_pkg::ST_MUL) begin
            r_prod <= mpa_pkg::PROD_W'(r_mag) * mpa_pkg::PROD_W'(r_mag);
        end

        unique case (r_state)
            mpa_pkg::ST_ACC: begin
                // load the sum as dividend (count already includes this sample)
                r_quo  <= mpa_pkg::SQ_W'(n_sum);
                r_rem  <= '0;
                r_step <= '0;
            end
            mpa_pkg::ST_DIV_SUM: begin
                if (r_step == mpa_pkg::LAST_STEP) begin
                    r_mean_hold <= n_quo[mpa_pkg::MAG_W-1:0];
                    r_quo       <= r_sq;
                    r_rem       <= '0;
                    r_step      <= '0;
                end else begin
                    r_quo  <= n_quo;
                    r_rem  <= n_rem;
                    r_step <= r_step + 1'b1;
                end
            end
            mpa_pkg::ST_DIV_SQ: begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == mpa_pkg::LAST_STEP) begin
                    r_ms_hold <= n_quo[mpa_pkg::MS_W-1:0];
                end
            end
            default: begin
            end
        endcase

        if (r_state == mpa_pkg::ST_FIN && w_out_free) begin
            r_mean      <= r_mean_hold;
            r_ms        <= r_ms_hold;
            r_out_count <= r_count;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mean_magnitude = r_mean;
    assign o_mean_square    = r_ms;
    assign o_sample_count   = r_out_count;
    assign o_overflowed     = r_out_ovf;

endmodule

>>> rtl/mpa_checker.sv
// Port-level checker for mean_power_accumulator_unit, bound into every instance of it.
// Depends on mpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [mpa_pkg::COUNT_W-1:0]  o_sample_count,
    input logic                         o_overflowed
);

    // a pending result transaction is not withdrawn
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // one sample in flight at a time
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a reported frame holds between one sample and the limit
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_out_valid,
        o_sample_count != '0 && o_sample_count <= mpa_pkg::FRAME_LIMIT)

    // overflow only once the count saturated
    `ASSERT_IMPL(a_ovf_full, i_clk, i_rst_n, o_out_valid && o_overflowed,
        o_sample_count == mpa_pkg::FRAME_LIMIT)

endmodule

bind mean_power_accumulator_unit mpa_checker u_mpa_checker (.*);
